### rtl/si_pkg.sv
// Package: widths and transfer types for the segment intersection pipeline.
`timescale 1ns / 1ps
package si_pkg;
	localparam int COORD_BITS = 16;
	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;        // coordinate difference
	localparam int PW = 2 * DW;        // product of two differences
	localparam int NW = PW + 1;        // d, un, vn
	localparam int MW = NW + DW;       // un * |delta|
	localparam int QW = DW;            // quotient, bounded by |delta|
	localparam int EW = CW + 3;        // start +/- quotient

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 negx;
		logic                 negy;
		logic [NW-1:0]        d;
		logic [MW-1:0]        prod_x;
		logic [MW-1:0]        prod_y;
	} front_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 negx;
		logic                 negy;
		logic [QW-1:0]        qx;
		logic [QW-1:0]        qy;
		logic                 remx_nz;
		logic                 remy_nz;
	} div_out_t;
endpackage

### rtl/si_front.sv
// Front end: differences, cross products, sign fix, range test, numerator products.
`timescale 1ns / 1ps
module si_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [8*si_pkg::CW-1:0]       in_data,
	output logic                          out_valid,
	output si_pkg::front_t                out_item
);
	import si_pkg::*;

	logic signed [CW-1:0] ix1, iy1, ix2, iy2, ix3, iy3, ix4, iy4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [CW-1:0] x1_s1, y1_s1, x1_s2, y1_s2, x1_s3, y1_s3, x1_s4, y1_s4;
	logic signed [CW-1:0] x1_s5, y1_s5;
	logic signed [DW-1:0] adx_s1, ady_s1, bdx_s1, bdy_s1, ox_s1, oy_s1;
	logic signed [DW-1:0] adx_s2, ady_s2, adx_s3, ady_s3, adx_s4, ady_s4;
	logic signed [PW-1:0] pd1_s2, pd2_s2, pu1_s2, pu2_s2, pv1_s2, pv2_s2;
	logic signed [NW-1:0] d_s3, un_s3, vn_s3, d_s4, un_s4, vn_s4;
	logic                 hit_s5, negx_s5, negy_s5;
	logic [DW-1:0]        magx_s5, magy_s5;
	logic [NW-1:0]        d_s5, un_s5;

	assign {iy4, ix4, iy3, ix3, iy2, ix2, iy1, ix1} = in_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: differences
			x1_s1  <= ix1;
			y1_s1  <= iy1;
			adx_s1 <= DW'(ix2) - DW'(ix1);
			ady_s1 <= DW'(iy2) - DW'(iy1);
			bdx_s1 <= DW'(ix4) - DW'(ix3);
			bdy_s1 <= DW'(iy4) - DW'(iy3);
			ox_s1  <= DW'(ix3) - DW'(ix1);
			oy_s1  <= DW'(iy3) - DW'(iy1);
			// s2: cross products
			x1_s2  <= x1_s1; y1_s2 <= y1_s1;
			adx_s2 <= adx_s1; ady_s2 <= ady_s1;
			pd1_s2 <= adx_s1 * bdy_s1;
			pd2_s2 <= ady_s1 * bdx_s1;
			pu1_s2 <= ox_s1 * bdy_s1;
			pu2_s2 <= oy_s1 * bdx_s1;
			pv1_s2 <= ox_s1 * ady_s1;
			pv2_s2 <= oy_s1 * adx_s1;
			// s3: determinants
			x1_s3  <= x1_s2; y1_s3 <= y1_s2;
			adx_s3 <= adx_s2; ady_s3 <= ady_s2;
			d_s3   <= NW'(pd1_s2) - NW'(pd2_s2);
			un_s3  <= NW'(pu1_s2) - NW'(pu2_s2);
			vn_s3  <= NW'(pv1_s2) - NW'(pv2_s2);
			// s4: make d positive
			x1_s4  <= x1_s3; y1_s4 <= y1_s3;
			adx_s4 <= adx_s3; ady_s4 <= ady_s3;
			d_s4   <= d_s3[NW-1] ? -d_s3 : d_s3;
			un_s4  <= d_s3[NW-1] ? -un_s3 : un_s3;
			vn_s4  <= d_s3[NW-1] ? -vn_s3 : vn_s3;
			// s5: range test, delta magnitudes
			x1_s5   <= x1_s4; y1_s5 <= y1_s4;
			hit_s5  <= (d_s4 != '0) && !un_s4[NW-1] && (un_s4 <= d_s4)
				&& !vn_s4[NW-1] && (vn_s4 <= d_s4);
			negx_s5 <= adx_s4[DW-1];
			negy_s5 <= ady_s4[DW-1];
			magx_s5 <= adx_s4[DW-1] ? DW'(-adx_s4) : DW'(adx_s4);
			magy_s5 <= ady_s4[DW-1] ? DW'(-ady_s4) : DW'(ady_s4);
			d_s5    <= NW'(d_s4);
			un_s5   <= NW'(un_s4);
			// s6: dividends
			out_item.hit    <= hit_s5;
			out_item.x1     <= x1_s5;
			out_item.y1     <= y1_s5;
			out_item.negx   <= negx_s5;
			out_item.negy   <= negy_s5;
			out_item.d      <= d_s5;
			out_item.prod_x <= MW'(un_s5) * MW'(magx_s5);
			out_item.prod_y <= MW'(un_s5) * MW'(magy_s5);
		end
	end

	assign out_valid = v_s6;
endmodule

### rtl/si_div.sv
// Pipelined restoring divider, one quotient bit per stage, x and y lanes share d.
`timescale 1ns / 1ps
module si_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  si_pkg::front_t    in_item,
	output logic              out_valid,
	output si_pkg::div_out_t  out_item
);
	import si_pkg::*;

	logic          v_q  [0:QW];
	logic [MW-1:0] rx_q [0:QW];
	logic [MW-1:0] ry_q [0:QW];
	logic [QW-1:0] qx_q [0:QW];
	logic [QW-1:0] qy_q [0:QW];
	logic [NW-1:0] d_q  [0:QW];
	front_t        sb_q [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_q[0] <= in_item.prod_x;
			ry_q[0] <= in_item.prod_y;
			qx_q[0] <= '0;
			qy_q[0] <= '0;
			d_q[0]  <= in_item.d;
			sb_q[0] <= in_item;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int SH = QW - 1 - k;
		logic [MW-1:0] dsh;
		logic [MW:0]   tx, ty;

		always_comb begin
			dsh = MW'({{DW{1'b0}}, d_q[k]} << SH);
			tx  = {1'b0, rx_q[k]} - {1'b0, dsh};
			ty  = {1'b0, ry_q[k]} - {1'b0, dsh};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_q[k+1] <= tx[MW] ? rx_q[k] : tx[MW-1:0];
				ry_q[k+1] <= ty[MW] ? ry_q[k] : ty[MW-1:0];
				qx_q[k+1] <= {qx_q[k][QW-2:0], ~tx[MW]};
				qy_q[k+1] <= {qy_q[k][QW-2:0], ~ty[MW]};
				d_q[k+1]  <= d_q[k];
				sb_q[k+1] <= sb_q[k];
			end
		end
	end

	assign out_valid        = v_q[QW];
	assign out_item.hit     = sb_q[QW].hit;
	assign out_item.x1      = sb_q[QW].x1;
	assign out_item.y1      = sb_q[QW].y1;
	assign out_item.negx    = sb_q[QW].negx;
	assign out_item.negy    = sb_q[QW].negy;
	assign out_item.qx      = qx_q[QW];
	assign out_item.qy      = qy_q[QW];
	assign out_item.remx_nz = (rx_q[QW] != '0);
	assign out_item.remy_nz = (ry_q[QW] != '0);
endmodule

### rtl/segment_intersection.sv
// Top level: 2-D segment intersection pipeline with streaming ports.
//
//  channel | dir | tdata                                   | tuser
//  s_axis  | in  | a_start_x,a_start_y,a_end_x,a_end_y,     | -
//          |     | b_start_x,b_start_y,b_end_x,b_end_y      |
//  m_axis  | out | point_x, point_y                        | hit
//
// One transfer in and one out per cycle when the sink keeps up.
// The pipeline is 6 front stages + 18 divider stages (input register and 17 quotient
// steps) + 1 output register;
// the divider's one-quotient-bit-per-stage chain sets the depth.
// Reset clears only valid bits; payload registers are left as they are.
// A stalled output freezes the whole pipeline: nothing is dropped or repeated.
`timescale 1ns / 1ps
module segment_intersection (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// tdata from bit 0: a_start_x, a_start_y, a_end_x, a_end_y,
	//                   b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [8*si_pkg::CW-1:0]      s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// tdata from bit 0: point_x, point_y
	output logic [2*si_pkg::CW-1:0]      m_axis_tdata,
	// tuser bit 0: hit
	output logic                         m_axis_tuser
);
	import si_pkg::*;

	localparam logic signed [EW-1:0] CMAX = EW'((1 << (CW - 1)) - 1);
	localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);

	logic     en;
	logic     fv, dv;
	front_t   fitem;
	div_out_t ditem;
	logic signed [EW-1:0] wx, wy;
	logic signed [CW-1:0] px, py;
	logic                 out_valid_q, hit_q;
	logic [2*CW-1:0]      data_q;

	// whole pipeline moves unless a result is waiting on the sink
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	si_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_axis_tvalid), .in_data(s_axis_tdata),
		.out_valid(fv), .out_item(fitem)
	);

	si_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(fv), .in_item(fitem),
		.out_valid(dv), .out_item(ditem)
	);

	// start +/- quotient, then truncate toward zero and clamp
	always_comb begin
		if (!ditem.negx) begin
			wx = EW'(ditem.x1) + EW'({1'b0, ditem.qx});
			if (ditem.remx_nz && wx[EW-1]) wx = wx + EW'(1);
		end else begin
			wx = EW'(ditem.x1) - EW'({1'b0, ditem.qx});
			if (ditem.remx_nz && !wx[EW-1] && wx != '0) wx = wx - EW'(1);
		end
		if (!ditem.negy) begin
			wy = EW'(ditem.y1) + EW'({1'b0, ditem.qy});
			if (ditem.remy_nz && wy[EW-1]) wy = wy + EW'(1);
		end else begin
			wy = EW'(ditem.y1) - EW'({1'b0, ditem.qy});
			if (ditem.remy_nz && !wy[EW-1] && wy != '0) wy = wy - EW'(1);
		end
		if (wx > CMAX)      px = CW'(CMAX);
		else if (wx < CMIN) px = CW'(CMIN);
		else                px = CW'(wx);
		if (wy > CMAX)      py = CW'(CMAX);
		else if (wy < CMIN) py = CW'(CMIN);
		else                py = CW'(wy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= ditem.hit;
			data_q <= ditem.hit ? {py, px} : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = hit_q;
endmodule

### rtl/si_checker.sv
// Port checker for the segment intersection block, bound to the top level.
`timescale 1ns / 1ps
module si_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_axis_tvalid,
	input logic                     s_axis_tready,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [2*si_pkg::CW-1:0]  m_axis_tdata,
	input logic                     m_axis_tuser
);
	import si_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a miss carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("miss with non-zero point");

	// input is taken whenever no result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// nothing appears on the output too soon after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid straight after reset");
endmodule

bind segment_intersection si_checker u_si_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
